>>> rtl/core/sfa_pkg.sv
// Package for the segregated-fit allocator: sizes, header and payload types,
// the sequencer state type and the size-class function.
// Used by every module under rtl/core; depends on nothing.
package sfa_pkg;

   localparam int POOL_BYTES   = 32768;
   localparam int NUM_BINS     = 5;
   localparam int HEADER_BYTES = 32;
   localparam int LIMIT_REGS   = 4;
   localparam int SLOTS        = POOL_BYTES / 4;

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SIZE_W  = $clog2(POOL_BYTES);
   localparam int NEED_W  = 17;
   localparam int OFF_W   = IDX_W + 5;
   localparam int VIS_W   = IDX_W + 1;
   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int CLS_W   = $clog2(NUM_BINS + 1);
   localparam int LIM_W   = 16;
   localparam int CSR_IDX_W = $clog2(LIMIT_REGS);

   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(POOL_BYTES - HEADER_BYTES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam logic ST_DONE  = 1'b0;
   localparam logic ST_NOFIT = 1'b1;

   typedef logic [LIMIT_REGS-1:0][LIM_W-1:0] lim_arr_type;

   typedef struct packed {
      logic                operation;
      logic [15:0]         request_size;
      logic [14:0]         free_address;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [14:0]         payload_address;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic                is_free;
      logic                has_next;
      logic                has_prev;
      logic [IDX_W-1:0]    next;
      logic [IDX_W-1:0]    prev;
   } hdr_type;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [IDX_W-1:0]    addr;
      hdr_type             wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_A_HEAD, S_A_CHK, S_A_UPRV, S_A_WPRV, S_A_UNXT,
      S_A_WNXT, S_A_UHEAD, S_A_WB, S_F_CHK, S_P_START, S_P_WHEAD,
      S_P_WNEW, S_RESP
   } st_type;

   // First class whose limit holds the size, else the last class.
   function automatic logic [CLS_W-1:0] class_of(logic [NEED_W-1:0] s,
                                                 lim_arr_type lim);
      logic [CLS_W-1:0] c;
      c = CLS_W'(NUM_BINS - 1);
      for (int i = LIMIT_REGS - 1; i >= 0; i--) begin
         if (i < NUM_BINS - 1 && s <= NEED_W'(lim[i])) c = CLS_W'(i);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/sfa_hdr_mem.sv
// Block header store: one header per 4-byte word, one port, registered read.
// Depends on sfa_pkg.
module sfa_hdr_mem (
   input  logic                clock,
   input  sfa_pkg::mem_req_type mem_req,
   output sfa_pkg::hdr_type    rd_data
);

   sfa_pkg::hdr_type hdr_mem [sfa_pkg::SLOTS];
   sfa_pkg::hdr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) hdr_mem[mem_req.addr] <= mem_req.wdata;
      if (mem_req.re) rd_data_ff <= hdr_mem[mem_req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sfa_seq.sv
// Allocation sequencer: walks the class lists, unlinks, splits and pushes
// blocks by read-modify-write on the header store; holds the class heads.
// Depends on sfa_pkg.
module sfa_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  sfa_pkg::lim_arr_type   lim,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sfa_pkg::req_type       req_data,
   output logic                   res_valid,
   input  logic                   res_take,
   output sfa_pkg::rsp_type       res_data,
   output sfa_pkg::mem_req_type   mem_req,
   input  sfa_pkg::hdr_type       rd_data
);

   localparam int IW = sfa_pkg::IDX_W;
   localparam int SW = sfa_pkg::SIZE_W;
   localparam int NW = sfa_pkg::NEED_W;
   localparam int OW = sfa_pkg::OFF_W;

   sfa_pkg::st_type          state_ff, state_in;
   logic [NW-1:0]            need_ff, need_in;
   logic [sfa_pkg::CLS_W-1:0] cls_ff, cls_in, pcls_ff, pcls_in;
   logic [sfa_pkg::VIS_W-1:0] visits_ff, visits_in;
   logic [IW-1:0]            cur_ff, cur_in, nidx_ff, nidx_in;
   logic [IW-1:0]            push_idx_ff, push_idx_in;
   logic [SW-1:0]            push_size_ff, push_size_in, nsize_ff, nsize_in;
   logic                     split_ff, split_in;
   sfa_pkg::hdr_type         b_ff, b_in;
   logic                     status_ff, status_in;
   logic [14:0]              addr_ff, addr_in;
   logic [IW-1:0]            head_ff [sfa_pkg::NUM_BINS];
   logic                     head_ok_ff [sfa_pkg::NUM_BINS];
   logic                     head_we, head_ok_wr;
   logic [IW-1:0]            head_wr;
   logic [sfa_pkg::BIN_W-1:0] head_sel, head_wsel;
   logic [IW-1:0]            head_q;
   logic                     head_ok_q;

   // Request decode, split arithmetic on the chosen block and class lookups.
   logic [SW-1:0]            rem;
   logic [OW-1:0]            noff;
   logic [OW-1:0]            nidx_w;
   logic [NW-1:0]            need_req;
   logic [14:0]              foff;
   logic                     fvalid;
   logic [sfa_pkg::CLS_W-1:0] cb, pc;

   assign head_q    = head_ff[head_sel];
   assign head_ok_q = head_ok_ff[head_sel];

   always_comb begin
      need_req = ({1'b0, req_data.request_size} + NW'(3)) & ~NW'(3);
      foff     = req_data.free_address - 15'(sfa_pkg::HEADER_BYTES);
      fvalid   = req_data.free_address != 15'd0
              && req_data.free_address >= 15'(sfa_pkg::HEADER_BYTES)
              && foff[1:0] == 2'b00
              && (foff >> 2) < 15'(sfa_pkg::SLOTS);
      rem      = b_ff.size - need_ff[SW-1:0];
      noff     = (OW'(cur_ff) << 2) + OW'(sfa_pkg::HEADER_BYTES) + OW'(need_ff);
      nidx_w   = noff >> 2;
      cb       = sfa_pkg::class_of(NW'(b_ff.size), lim);
      pc       = sfa_pkg::class_of(NW'(push_size_ff), lim);
   end

   always_comb begin
      state_in     = state_ff;
      need_in      = need_ff;
      cls_in       = cls_ff;
      pcls_in      = pcls_ff;
      visits_in    = visits_ff;
      cur_in       = cur_ff;
      nidx_in      = nidx_ff;
      push_idx_in  = push_idx_ff;
      push_size_in = push_size_ff;
      nsize_in     = nsize_ff;
      split_in     = split_ff;
      b_in         = b_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      head_we      = 1'b0;
      head_wr      = '0;
      head_ok_wr   = 1'b0;
      head_wsel    = '0;
      head_sel     = cls_ff[sfa_pkg::BIN_W-1:0];
      mem_req      = '0;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      unique case (state_ff)
         sfa_pkg::S_INIT: begin
            mem_req.we            = 1'b1;
            mem_req.addr          = '0;
            mem_req.wdata.size    = sfa_pkg::INIT_SIZE;
            mem_req.wdata.is_free = 1'b1;
            state_in              = sfa_pkg::S_IDLE;
         end
         sfa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in = sfa_pkg::ST_DONE;
               addr_in   = '0;
               if (req_data.operation == sfa_pkg::OP_ALLOC) begin
                  need_in   = need_req;
                  cls_in    = sfa_pkg::class_of(need_req, lim);
                  visits_in = '0;
                  state_in  = sfa_pkg::S_A_HEAD;
               end else if (fvalid) begin
                  push_idx_in  = IW'(foff >> 2);
                  mem_req.re   = 1'b1;
                  mem_req.addr = IW'(foff >> 2);
                  state_in     = sfa_pkg::S_F_CHK;
               end else begin
                  state_in = sfa_pkg::S_RESP;
               end
            end
         end
         sfa_pkg::S_A_HEAD: begin
            if (cls_ff >= sfa_pkg::CLS_W'(sfa_pkg::NUM_BINS)) begin
               status_in = sfa_pkg::ST_NOFIT;
               state_in  = sfa_pkg::S_RESP;
            end else if (head_ok_q) begin
               cur_in       = head_q;
               mem_req.re   = 1'b1;
               mem_req.addr = head_q;
               state_in     = sfa_pkg::S_A_CHK;
            end else begin
               cls_in = cls_ff + 1'b1;
            end
         end
         sfa_pkg::S_A_CHK: begin
            if (visits_ff >= sfa_pkg::VIS_W'(sfa_pkg::SLOTS)) begin
               status_in = sfa_pkg::ST_NOFIT;
               state_in  = sfa_pkg::S_RESP;
            end else begin
               visits_in = visits_ff + 1'b1;
               if (rd_data.is_free && NW'(rd_data.size) >= need_ff) begin
                  b_in     = rd_data;
                  state_in = sfa_pkg::S_A_UPRV;
               end else if (rd_data.has_next) begin
                  cur_in       = rd_data.next;
                  mem_req.re   = 1'b1;
                  mem_req.addr = rd_data.next;
               end else begin
                  cls_in   = cls_ff + 1'b1;
                  state_in = sfa_pkg::S_A_HEAD;
               end
            end
         end
         sfa_pkg::S_A_UPRV: begin
            if (b_ff.has_prev) begin
               mem_req.re   = 1'b1;
               mem_req.addr = b_ff.prev;
               state_in     = sfa_pkg::S_A_WPRV;
            end else begin
               state_in = sfa_pkg::S_A_UNXT;
            end
         end
         sfa_pkg::S_A_WPRV: begin
            mem_req.we             = 1'b1;
            mem_req.addr           = b_ff.prev;
            mem_req.wdata          = rd_data;
            mem_req.wdata.has_next = b_ff.has_next;
            mem_req.wdata.next     = b_ff.next;
            state_in               = sfa_pkg::S_A_UNXT;
         end
         sfa_pkg::S_A_UNXT: begin
            if (b_ff.has_next) begin
               mem_req.re   = 1'b1;
               mem_req.addr = b_ff.next;
               state_in     = sfa_pkg::S_A_WNXT;
            end else begin
               state_in = sfa_pkg::S_A_UHEAD;
            end
         end
         sfa_pkg::S_A_WNXT: begin
            mem_req.we             = 1'b1;
            mem_req.addr           = b_ff.next;
            mem_req.wdata          = rd_data;
            mem_req.wdata.has_prev = b_ff.has_prev;
            mem_req.wdata.prev     = b_ff.prev;
            state_in               = sfa_pkg::S_A_UHEAD;
         end
         sfa_pkg::S_A_UHEAD: begin
            // The head is matched under the class of the original size.
            head_sel = cb[sfa_pkg::BIN_W-1:0];
            if (head_ok_q && head_q == cur_ff) begin
               head_we    = 1'b1;
               head_wsel  = cb[sfa_pkg::BIN_W-1:0];
               head_wr    = b_ff.next;
               head_ok_wr = b_ff.has_next;
            end
            split_in     = rem > SW'(sfa_pkg::HEADER_BYTES + 4)
                        && nidx_w < OW'(sfa_pkg::SLOTS);
            nidx_in      = IW'(nidx_w);
            nsize_in     = rem - SW'(sfa_pkg::HEADER_BYTES);
            addr_in      = 15'((OW'(cur_ff) << 2) + OW'(sfa_pkg::HEADER_BYTES));
            // Re-read the block: unlinking may have touched its own links.
            mem_req.re   = 1'b1;
            mem_req.addr = cur_ff;
            state_in     = sfa_pkg::S_A_WB;
         end
         sfa_pkg::S_A_WB: begin
            mem_req.we            = 1'b1;
            mem_req.addr          = cur_ff;
            mem_req.wdata         = rd_data;
            mem_req.wdata.is_free = 1'b0;
            if (split_ff) begin
               mem_req.wdata.size = need_ff[SW-1:0];
               push_idx_in        = nidx_ff;
               push_size_in       = nsize_ff;
               state_in           = sfa_pkg::S_P_START;
            end else begin
               state_in = sfa_pkg::S_RESP;
            end
         end
         sfa_pkg::S_F_CHK: begin
            if (rd_data.is_free) begin
               state_in = sfa_pkg::S_RESP;
            end else begin
               push_size_in = rd_data.size;
               state_in     = sfa_pkg::S_P_START;
            end
         end
         sfa_pkg::S_P_START: begin
            head_sel = pc[sfa_pkg::BIN_W-1:0];
            pcls_in  = pc;
            if (head_ok_q) begin
               mem_req.re   = 1'b1;
               mem_req.addr = head_q;
               state_in     = sfa_pkg::S_P_WHEAD;
            end else begin
               state_in = sfa_pkg::S_P_WNEW;
            end
         end
         sfa_pkg::S_P_WHEAD: begin
            head_sel               = pcls_ff[sfa_pkg::BIN_W-1:0];
            mem_req.we             = 1'b1;
            mem_req.addr           = head_q;
            mem_req.wdata          = rd_data;
            mem_req.wdata.has_prev = 1'b1;
            mem_req.wdata.prev     = push_idx_ff;
            state_in               = sfa_pkg::S_P_WNEW;
         end
         sfa_pkg::S_P_WNEW: begin
            head_sel               = pcls_ff[sfa_pkg::BIN_W-1:0];
            mem_req.we             = 1'b1;
            mem_req.addr           = push_idx_ff;
            mem_req.wdata.size     = push_size_ff;
            mem_req.wdata.is_free  = 1'b1;
            mem_req.wdata.has_next = head_ok_q;
            mem_req.wdata.next     = head_q;
            head_we                = 1'b1;
            head_wsel              = pcls_ff[sfa_pkg::BIN_W-1:0];
            head_wr                = push_idx_ff;
            head_ok_wr             = 1'b1;
            state_in               = sfa_pkg::S_RESP;
         end
         sfa_pkg::S_RESP: begin
            res_valid = 1'b1;
            if (res_take) state_in = sfa_pkg::S_IDLE;
         end
         default: state_in = sfa_pkg::S_IDLE;
      endcase
   end

   assign res_data.status          = status_ff;
   assign res_data.payload_address = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfa_pkg::S_INIT;
         for (int i = 0; i < sfa_pkg::NUM_BINS; i++) begin
            head_ff[i]    <= '0;
            head_ok_ff[i] <= (i == sfa_pkg::NUM_BINS - 1);
         end
      end else begin
         state_ff <= state_in;
         if (head_we) begin
            head_ff[head_wsel]    <= head_wr;
            head_ok_ff[head_wsel] <= head_ok_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff      <= need_in;
      cls_ff       <= cls_in;
      pcls_ff      <= pcls_in;
      visits_ff    <= visits_in;
      cur_ff       <= cur_in;
      nidx_ff      <= nidx_in;
      push_idx_ff  <= push_idx_in;
      push_size_ff <= push_size_in;
      nsize_ff     <= nsize_in;
      split_ff     <= split_in;
      b_ff         <= b_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
   end

   // The store has one port: never a read and a write in the same cycle.
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("header store read and written in one cycle");

   // A result that waits keeps its value until it is taken.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_take |=> res_valid && $stable(res_data))
      else $error("pending result changed");

   // A no-fit result never carries an address.
   a_nofit_addr: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_data.status == sfa_pkg::ST_NOFIT
         |-> res_data.payload_address == 15'd0)
      else $error("no-fit result with an address");

   // The walk never goes past its visit bound.
   a_visits: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfa_pkg::S_A_CHK |-> visits_ff <= sfa_pkg::VIS_W'(sfa_pkg::SLOTS))
      else $error("visit count past bound");

endmodule

>>> rtl/core/segregated_fit_allocator.sv
// Top level of the segregated-fit allocator: class limit registers, result
// register, header store and sequencer. Depends on sfa_pkg, sfa_hdr_mem, sfa_seq.
//
//   channel   ports              direction  payload
//   request   req_valid/ready    in         req_data (operation, size, address)
//   result    rsp_valid/ready    out        rsp_data (status, payload address)
//   config    csr_we             in         csr_index, csr_wdata (class limits)
//
// One item is in work at a time. A free reads the block header and, if the block
// is in use, pushes it on its class list before its result is registered; an
// allocate looks at each class head in turn and walks its list entries, then
// unlinks, splits and pushes, all through the single header store port. After its
// result is taken the sequencer returns to idle and accepts the next item. After
// reset the init state writes the initial pool header before the first item. The
// result register lets the next item be worked while the previous result waits.
module segregated_fit_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sfa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sfa_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [sfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfa_pkg::LIM_W-1:0]   csr_wdata
);

   sfa_pkg::lim_arr_type  lim_ff;
   logic                  rsp_valid_ff;
   sfa_pkg::rsp_type      rsp_data_ff;
   sfa_pkg::mem_req_type  mem_req;
   sfa_pkg::hdr_type      rd_data;
   logic                  res_valid;
   logic                  res_take;
   sfa_pkg::rsp_type      res_data;

   assign res_take = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff[0]    <= 16'd32;
         lim_ff[1]    <= 16'd64;
         lim_ff[2]    <= 16'd128;
         lim_ff[3]    <= 16'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) lim_ff[csr_index] <= csr_wdata;
         if (res_take) rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take && res_valid) rsp_data_ff <= res_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sfa_hdr_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   sfa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .lim       (lim_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

endmodule

>>> test/segregated_fit_allocator_test.sv
// Testbench for segregated_fit_allocator: drives allocate and free items,
// predicts each result with its own free-list model and checks every one.
// Depends on sfa_pkg and the segregated_fit_allocator RTL.
`timescale 1ns / 100ps

module segregated_fit_allocator_test;
   import sfa_pkg::*;

   localparam int WATCHDOG_CYCLES = 400000;

   typedef struct {
      int unsigned size;
      bit          is_free;
      bit          has_next;
      bit          has_prev;
      int unsigned next;
      int unsigned prev;
   } blk_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LIM_W-1:0]     csr_wdata = '0;

   // Predictor state.
   blk_type     pool_hdr [SLOTS];
   int unsigned list_head [NUM_BINS];
   bit          list_ok [NUM_BINS];
   int unsigned class_limit [LIMIT_REGS];

   rsp_type     expected_rsps [$];
   int unsigned live_blocks [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   segregated_fit_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned size_class(int unsigned s);
      for (int i = 0; i < NUM_BINS - 1 && i < LIMIT_REGS; i++)
         if (s <= class_limit[i]) return i;
      return NUM_BINS - 1;
   endfunction

   function automatic void push_free(int unsigned idx);
      int unsigned c;
      c = size_class(pool_hdr[idx].size);
      pool_hdr[idx].has_next = list_ok[c];
      pool_hdr[idx].next = list_head[c];
      if (list_ok[c] && list_head[c] < SLOTS) begin
         pool_hdr[list_head[c]].has_prev = 1'b1;
         pool_hdr[list_head[c]].prev = idx;
      end
      pool_hdr[idx].has_prev = 1'b0;
      pool_hdr[idx].prev = 0;
      list_head[c] = idx;
      list_ok[c] = 1'b1;
   endfunction

   function automatic void unlink_free(int unsigned idx);
      blk_type b;
      int unsigned c;
      b = pool_hdr[idx];
      c = size_class(b.size);
      if (b.has_prev && b.prev < SLOTS) begin
         pool_hdr[b.prev].has_next = b.has_next;
         pool_hdr[b.prev].next = b.next;
      end
      if (b.has_next && b.next < SLOTS) begin
         pool_hdr[b.next].has_prev = b.has_prev;
         pool_hdr[b.next].prev = b.prev;
      end
      if (list_ok[c] && list_head[c] == idx) begin
         list_head[c] = b.next;
         list_ok[c] = b.has_next;
      end
   endfunction

   function automatic rsp_type allocate_block(int unsigned req);
      int unsigned need, visits, cur, rem, nidx;
      bit ok;
      rsp_type r;
      need = (req + 3) & ~32'd3;
      visits = 0;
      r.status = ST_NOFIT;
      r.payload_address = '0;
      for (int unsigned c = size_class(need); c < NUM_BINS; c++) begin
         ok = list_ok[c];
         cur = list_head[c];
         while (ok && cur < SLOTS) begin
            if (visits >= SLOTS) return r;
            visits++;
            if (pool_hdr[cur].is_free && pool_hdr[cur].size >= need) begin
               rem = pool_hdr[cur].size - need;
               unlink_free(cur);
               pool_hdr[cur].is_free = 1'b0;
               if (rem > HEADER_BYTES + 4) begin
                  nidx = (cur * 4 + HEADER_BYTES + need) >> 2;
                  if (nidx < SLOTS) begin
                     pool_hdr[nidx] = '{rem - HEADER_BYTES, 1'b1, 1'b0, 1'b0, 0, 0};
                     pool_hdr[cur].size = need;
                     push_free(nidx);
                  end
               end
               r.status = ST_DONE;
               r.payload_address = 15'(cur * 4 + HEADER_BYTES);
               return r;
            end
            ok = pool_hdr[cur].has_next;
            cur = pool_hdr[cur].next;
         end
      end
      return r;
   endfunction

   function automatic void release_block(int unsigned addr);
      int unsigned idx;
      if (addr == 0 || addr < HEADER_BYTES) return;
      if (((addr - HEADER_BYTES) & 3) != 0) return;
      idx = (addr - HEADER_BYTES) >> 2;
      if (idx >= SLOTS) return;
      if (pool_hdr[idx].is_free) return;
      pool_hdr[idx].is_free = 1'b1;
      push_free(idx);
   endfunction

   function automatic void reset_pool();
      foreach (pool_hdr[i]) pool_hdr[i] = '{0, 1'b0, 1'b0, 1'b0, 0, 0};
      foreach (list_ok[i]) begin
         list_ok[i] = 1'b0;
         list_head[i] = 0;
      end
      class_limit = '{32, 64, 128, 256};
      pool_hdr[0].size = POOL_BYTES - HEADER_BYTES;
      pool_hdr[0].is_free = 1'b1;
      list_ok[NUM_BINS - 1] = 1'b1;
   endfunction

   // Sends one item, predicting its result at the accepting edge.
   task automatic send_item(logic op, int unsigned sz, int unsigned addr);
      rsp_type r;
      req_valid <= 1'b1;
      req_data <= '{op, 16'(sz), 15'(addr)};
      do @(posedge clock); while (!req_ready);
      if (op == OP_ALLOC) begin
         r = allocate_block(sz & 16'hFFFF);
         if (r.status == ST_DONE) live_blocks.push_back(r.payload_address);
      end else begin
         release_block(addr & 15'h7FFF);
         r = '{ST_DONE, 15'd0};
      end
      expected_rsps.push_back(r);
      @(negedge clock);
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_alloc(int unsigned sz);
      send_item(OP_ALLOC, sz, $urandom_range(0, 32767));
   endtask

   task automatic send_free(int unsigned addr);
      send_item(OP_FREE, $urandom_range(0, 65535), addr);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_limit(int unsigned idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= LIM_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      class_limit[idx] = val & 16'hFFFF;
   endtask

   // Picks a live block most of the time; otherwise a bad address below the header size.
   function automatic int unsigned pick_free_addr();
      int unsigned k;
      if (live_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         pick_free_addr = live_blocks[k];
         live_blocks.delete(k);
      end else begin
         pick_free_addr = $urandom_range(0, 31);
      end
   endfunction

   task automatic test_directed();
      send_alloc(0);
      send_alloc(1);
      send_alloc(16'hFFFF);
      send_alloc(32768);
      send_alloc(30000);
      send_alloc(100);
      send_free(0);
      send_free(5);
      send_free(33);
      send_free(32767);
      send_free(HEADER_BYTES);
      send_free(HEADER_BYTES);
      send_alloc(2);
      send_alloc(255);
      send_alloc(257);
      send_alloc(16'h5555);
      send_alloc(16'h2AAA);
      send_free(15'h2AAA);
      send_free(15'h5556);
      drain();
   endtask

   task automatic test_random(int n, int unsigned max_sz);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0) send_alloc($urandom_range(0, max_sz));
         else send_free(pick_free_addr());
      end
      drain();
   endtask

   task automatic test_limits();
      write_limit(0, 0);
      write_limit(1, 16);
      write_limit(2, 32768);
      write_limit(3, 65535);
      test_random(150, 600);
      write_limit(0, 32768);
      write_limit(1, 0);
      write_limit(2, 8);
      write_limit(3, 12);
      test_random(150, 600);
      write_limit(0, 48);
      write_limit(1, 96);
      write_limit(2, 200);
      write_limit(3, 512);
      test_random(150, 400);
   endtask

   // The receiver holds off while the sender keeps offering items.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_alloc($urandom_range(0, 128));
      join
      drain();
   endtask

   initial begin
      reset_pool();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(350, 300);
      test_backpressure();
      test_limits();
      stim_done = 1'b1;
   end

   // The receiver stalls in a rhythm unrelated to the sender.
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 40) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no item outstanding: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.payload_address !== want.payload_address) begin
               $error("payload_address: expected %0d, got %0d",
                      want.payload_address, rsp_data.payload_address);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end else if (stim_done) begin
         if (error_count == 0 && expected_rsps.size() == 0)
            $display("TB_OK");
         else
            $display("TB_ERROR");
         $finish;
      end
   end

endmodule
